[hdl/iirtf_pkg.sv]
// Shared types, constants and codes for the direct form I IIR filter.
`default_nettype none

package iirtf_pkg;

   // Tap counts of the filter structure.
   localparam int NUM_TAPS      = 4;
   localparam int FEEDBACK_TAPS = 3;
   localparam int NUM_STEPS     = NUM_TAPS + FEEDBACK_TAPS;
   localparam int STEP_W        = (NUM_STEPS > 1) ? $clog2(NUM_STEPS) : 1;

   // Coefficient registers that exist; taps past these use a zero coefficient.
   localparam int NUM_REGS_B = 4;
   localparam int NUM_REGS_A = 3;

   // Data formats.
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 18;
   localparam int FRAC_BITS = 14;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int ACC_W     = PROD_W + STEP_W;
   localparam int REG_IDX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_B3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_A3 = 3'd6;

   // Reset value of coefficient b0 (1.0 in Q4.14).
   localparam logic signed [COEF_W-1:0] COEF_ONE = 18'sd16384;

   // Command codes carried in tuser of the request channel.
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_WRITE
   } iirtf_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              hist_push;
      logic              hist_clear;
      logic              acc_clear;
      logic              mul_en;
      logic              acc_add;
      logic              out_push;
      logic [STEP_W-1:0] step;
   } iirtf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_busy;
   } iirtf_sts_type;

endpackage

`default_nettype wire

[hdl/iirtf_ctrl.sv]
// Controller state machine that sequences the shared multiply-accumulate.
`default_nettype none

module iirtf_ctrl
   import iirtf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic          req_tuser,
   input  wire iirtf_sts_type sts,
   output iirtf_cmd_type      cmd
);

   iirtf_state_type   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      step_in        = step_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.step       = step_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == CMD_CLEAR) begin
                  cmd.hist_clear = 1'b1;
               end else begin
                  cmd.hist_push = 1'b1;
                  cmd.acc_clear = 1'b1;
                  step_in       = '0;
                  state_in      = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            // The product of the previous step is added while the next one forms.
            cmd.mul_en  = 1'b1;
            cmd.acc_add = (step_ff != '0);
            if (step_ff == STEP_W'(NUM_STEPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_WRITE;
         end
         ST_WRITE: begin
            if (!sts.out_busy) begin
               cmd.out_push = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/iirtf_datapath.sv]
// Datapath: coefficients, histories, shared multiplier, accumulator, output register.
`default_nettype none

module iirtf_datapath
   import iirtf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_addr,
   input  wire logic [COEF_W-1:0]    csr_wdata,
   input  wire logic [SAMPLE_W-1:0]  req_tdata,
   output logic [SAMPLE_W-1:0]       rsp_tdata,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire iirtf_cmd_type        cmd,
   output iirtf_sts_type             sts
);

   logic signed [COEF_W-1:0]   coef_b_ff [NUM_REGS_B];
   logic signed [COEF_W-1:0]   coef_a_ff [NUM_REGS_A];
   logic signed [SAMPLE_W-1:0] x_ff      [NUM_TAPS];
   logic signed [SAMPLE_W-1:0] y_ff      [FEEDBACK_TAPS];

   logic signed [COEF_W-1:0]   op_coef   [NUM_STEPS];
   logic signed [SAMPLE_W-1:0] op_data   [NUM_STEPS];
   logic                       op_sub    [NUM_STEPS];

   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic                       sub_ff, sub_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff;

   logic signed [ACC_W-1:0]           acc_rnd;
   logic signed [ACC_W-FRAC_BITS-1:0] acc_q;
   logic signed [SAMPLE_W-1:0]        y_sat;

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS_B; i++) coef_b_ff[i] <= '0;
         for (int i = 0; i < NUM_REGS_A; i++) coef_a_ff[i] <= '0;
         coef_b_ff[0] <= COEF_ONE;
      end else if (csr_we) begin
         case (csr_addr)
            REG_B0:  coef_b_ff[0] <= csr_wdata;
            REG_B1:  coef_b_ff[1] <= csr_wdata;
            REG_B2:  coef_b_ff[2] <= csr_wdata;
            REG_B3:  coef_b_ff[3] <= csr_wdata;
            REG_A1:  coef_a_ff[0] <= csr_wdata;
            REG_A2:  coef_a_ff[1] <= csr_wdata;
            REG_A3:  coef_a_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Operand list: numerator taps first, then feedback taps.
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         op_coef[k] = '0;
         if (k < NUM_REGS_B) op_coef[k] = coef_b_ff[k];
         op_data[k] = x_ff[k];
         op_sub[k]  = 1'b0;
      end
      for (int k = 0; k < FEEDBACK_TAPS; k++) begin
         op_coef[NUM_TAPS + k] = '0;
         if (k < NUM_REGS_A) op_coef[NUM_TAPS + k] = coef_a_ff[k];
         op_data[NUM_TAPS + k] = y_ff[k];
         op_sub[NUM_TAPS + k]  = 1'b1;
      end
   end

   assign prod_in = op_coef[cmd.step] * op_data[cmd.step];
   assign sub_in  = op_sub[cmd.step];

   always_comb begin
      acc_in = acc_ff;
      if (cmd.acc_clear) begin
         acc_in = '0;
      end else if (cmd.acc_add) begin
         if (sub_ff) acc_in = acc_ff - ACC_W'(prod_ff);
         else        acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
         sub_ff  <= sub_in;
      end
      acc_ff <= acc_in;
   end

   // Round half up, then saturate to the sample range.
   always_comb begin
      acc_rnd = acc_ff + ACC_W'(1 << (FRAC_BITS - 1));
      acc_q   = acc_rnd[ACC_W-1:FRAC_BITS];
      if (acc_q > (ACC_W-FRAC_BITS)'(32767)) begin
         y_sat = 16'sh7FFF;
      end else if (acc_q < -(ACC_W-FRAC_BITS)'(32768)) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = acc_q[SAMPLE_W-1:0];
      end
   end

   // Histories, newest first.
   always_ff @(posedge clock) begin
      if (reset || cmd.hist_clear) begin
         for (int i = 0; i < NUM_TAPS; i++)      x_ff[i] <= '0;
         for (int i = 0; i < FEEDBACK_TAPS; i++) y_ff[i] <= '0;
      end else begin
         if (cmd.hist_push) begin
            for (int i = NUM_TAPS - 1; i > 0; i--) x_ff[i] <= x_ff[i-1];
            x_ff[0] <= req_tdata;
         end
         if (cmd.out_push) begin
            for (int i = FEEDBACK_TAPS - 1; i > 0; i--) y_ff[i] <= y_ff[i-1];
            y_ff[0] <= y_sat;
         end
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_push)    rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_push) rsp_data_ff <= y_sat;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_tready;

endmodule

`default_nettype wire

[hdl/iir_transfer_function_filter.sv]
// Top level of the direct form I IIR filter with a shared multiply-accumulate.
//
//   Channel   Ports        Direction  Contents
//   request   req_t*       in         tdata: sample_in; tuser: command
//   response  rsp_t*       out        tdata: sample_out
//   config    csr_*        in         write of coefficient b0..b3, a1..a3
//
// A filter transaction occupies the block from acceptance until its result is
// written: ST_IDLE accepts it, ST_MAC walks the seven taps one by one through
// the single 18x16 multiplier, ST_DRAIN adds the last product and ST_WRITE
// rounds and stores the result in the output register, which offers it.
// A clear transaction zeroes both histories, leaves the block idle and produces no response.
// Reset is synchronous: coefficients return to b0 = 1.0 and the rest zero,
// and both histories are zeroed. A stalled response holds in the output
// register while the next request is accepted; the block waits only if a
// new result is ready before the previous one has been taken.
`default_nettype none

module iir_transfer_function_filter
   import iirtf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request channel.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [SAMPLE_W-1:0]  req_tdata,   // [15:0] sample_in
   input  wire logic                 req_tuser,   // [0] command
   // Response channel.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [SAMPLE_W-1:0]       rsp_tdata,   // [15:0] sample_out
   // Configuration write port.
   input  wire logic                 csr_we,
   input  wire logic [REG_IDX_W-1:0] csr_addr,
   input  wire logic [COEF_W-1:0]    csr_wdata
);

   iirtf_cmd_type ctrl_cmd;
   iirtf_sts_type dp_sts;

   // The controller walks the taps and decides when a result is written.
   iirtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .sts        (dp_sts),
      .cmd        (ctrl_cmd)
   );

   // The datapath holds coefficients, histories, the multiplier and the output register.
   iirtf_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (ctrl_cmd),
      .sts        (dp_sts)
   );

   // A filter transaction occupies the block, so the next cycle is not ready.
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_FILTER) |=> !req_tready)
      else $error("request accepted while a filter transaction was running");

   // A clear transaction finishes at once and the block is ready again.
   a_clear_quick: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_CLEAR) |=> req_tready)
      else $error("clear transaction did not return to idle");

   // A result is written only into a free or draining output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_push |-> (!rsp_tvalid || rsp_tready))
      else $error("pending response overwritten");

   // A written result is offered in the next cycle.
   a_push_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_push |=> rsp_tvalid)
      else $error("written result not offered on the response channel");

endmodule

`default_nettype wire
